// ===== rtl/uds_sess_pkg.sv =====
// package: types and constants shared by the diagnostic session client
`default_nettype none
package uds_sess_pkg;

  localparam int unsigned CFG_AW = 4;

  localparam logic [1:0] REG_P2      = 2'd0;
  localparam logic [1:0] REG_P2_STAR = 2'd1;
  localparam logic [1:0] REG_S3      = 2'd2;

  localparam logic [15:0] P2_RESET      = 16'd10;
  localparam logic [15:0] P2_STAR_RESET = 16'd1000;
  localparam logic [15:0] S3_RESET      = 16'd400;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_REQUEST  = 3'd1;
  localparam logic [2:0] CMD_TX_DONE  = 3'd2;
  localparam logic [2:0] CMD_FIRST    = 3'd3;
  localparam logic [2:0] CMD_RESPONSE = 3'd4;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_REQUEST    = 3'd1;
  localparam logic [2:0] ST_CONFIRM    = 3'd2;
  localparam logic [2:0] ST_FIRST      = 3'd3;
  localparam logic [2:0] ST_INDICATION = 3'd4;
  localparam logic [2:0] ST_PENDING    = 3'd5;

  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_NOT_OK  = 3'd1;
  localparam logic [2:0] RC_BUSY    = 3'd2;
  localparam logic [2:0] RC_FORMAT  = 3'd3;
  localparam logic [2:0] RC_PENDING = 3'd4;

  localparam logic [7:0]  NO_ID       = 8'hFF;
  localparam logic [8:0]  POS_OFFSET  = 9'h040;
  localparam logic [7:0]  NEG_SID     = 8'h7F;
  localparam logic [7:0]  NRC_PENDING = 8'h78;
  localparam logic [11:0] NEG_LEN     = 12'd3;
  localparam logic [7:0]  TP_SID      = 8'h3E;
  localparam logic [23:0] TP_PARAMS   = 24'h800000;
  localparam logic [2:0]  TP_LEN      = 3'd2;
  localparam logic [2:0]  MAX_LEN     = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic        result_ok;
    logic [7:0]  channel;
    logic        functional;
    logic [7:0]  service_id;
    logic [23:0] request_params;
    logic [2:0]  request_length;
    logic [11:0] rx_length;
    logic [7:0]  resp_first;
    logic [7:0]  resp_second;
    logic [7:0]  resp_third;
    logic [7:0]  connected_server;
  } sess_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  session_state;
    logic        send_request;
    logic        send_tester;
    logic [7:0]  send_channel;
    logic [7:0]  send_service;
    logic [23:0] send_params;
    logic [2:0]  send_length;
    logic        timeout_flag;
    logic        negative_flag;
    logic [7:0]  negative_code;
    logic        positive_flag;
  } sess_out_t;

  typedef struct packed {
    logic [15:0] p2_ticks;
    logic [15:0] p2_star_ticks;
    logic [15:0] s3_ticks;
  } sess_cfg_t;

  typedef struct packed {
    logic [2:0]  session;
    logic        addr_functional;
    logic [7:0]  pending_service;
    logic [7:0]  pending_channel;
    logic        p2_running;
    logic [15:0] p2_count;
    logic [15:0] s3_count;
    logic [7:0]  last_server;
  } sess_state_t;

  localparam sess_state_t STATE_RESET = '{
    session:         ST_IDLE,
    addr_functional: 1'b0,
    pending_service: 8'h00,
    pending_channel: NO_ID,
    p2_running:      1'b0,
    p2_count:        16'd0,
    s3_count:        16'd0,
    last_server:     NO_ID
  };

endpackage
`default_nettype wire

// ===== rtl/uds_sess_cfg.sv =====
// apb timing register file for p2, p2 star and s3 reloads
`default_nettype none
module uds_sess_cfg
  import uds_sess_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output sess_cfg_t              cfg_o
);

  sess_cfg_t cfg_q;
  logic      wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.p2_ticks      <= P2_RESET;
      cfg_q.p2_star_ticks <= P2_STAR_RESET;
      cfg_q.s3_ticks      <= S3_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_P2:      cfg_q.p2_ticks      <= pwdata[15:0];
        REG_P2_STAR: cfg_q.p2_star_ticks <= pwdata[15:0];
        REG_S3:      cfg_q.s3_ticks      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_P2:      prdata = {16'd0, cfg_q.p2_ticks};
      REG_P2_STAR: prdata = {16'd0, cfg_q.p2_star_ticks};
      REG_S3:      prdata = {16'd0, cfg_q.s3_ticks};
      default:     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/uds_sess_step.sv =====
// next-state and result logic for one session transaction
`default_nettype none
module uds_sess_step
  import uds_sess_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS   = 6,
  parameter int unsigned FUNC_SERVER_ID = 5
) (
  input  wire sess_in_t    item_i,
  input  wire sess_state_t cur_i,
  input  wire sess_cfg_t   cfg_i,
  output sess_state_t      nxt_o,
  output sess_out_t        res_o
);

  localparam logic [7:0] FUNC_CH  = 8'(NUM_CHANNELS - 1);
  localparam logic [7:0] NUM_CH   = 8'(NUM_CHANNELS);
  localparam logic [7:0] FUNC_SRV = 8'(FUNC_SERVER_ID);

  sess_state_t nxt;
  sess_out_t   res;
  logic [15:0] p2_dec;
  logic [15:0] s3_dec;
  logic [7:0]  req_ch;
  logic [2:0]  req_len;
  logic [7:0]  srv;
  logic        accept_rsp;
  logic [2:0]  rc;

  assign p2_dec  = cur_i.p2_count - 16'd1;
  assign s3_dec  = cur_i.s3_count - 16'd1;
  assign srv     = item_i.connected_server;
  assign req_ch  = item_i.functional ? FUNC_CH : item_i.channel;
  assign req_len = (item_i.request_length > MAX_LEN) ? MAX_LEN : item_i.request_length;

  // response checks
  always_comb begin
    rc = RC_OK;
    if (item_i.resp_first == NEG_SID) begin
      priority if (item_i.resp_second != cur_i.pending_service ||
                   item_i.rx_length != NEG_LEN) begin
        rc = RC_FORMAT;
      end else if (item_i.resp_third == NRC_PENDING) begin
        rc = cur_i.addr_functional ? RC_FORMAT : RC_PENDING;
      end else begin
        rc = RC_OK;
      end
    end else if (({1'b0, cur_i.pending_service} + POS_OFFSET) !=
                 {1'b0, item_i.resp_first}) begin
      rc = RC_FORMAT;
    end
  end

  always_comb begin
    nxt        = cur_i;
    res        = '0;
    accept_rsp = 1'b0;
    unique case (item_i.command)
      CMD_TICK: begin
        if (cur_i.p2_running) begin
          nxt.p2_count = p2_dec;
          if (p2_dec == 16'd0) begin
            nxt.session         = ST_IDLE;
            nxt.pending_channel = NO_ID;
            nxt.p2_running      = 1'b0;
            res.timeout_flag    = 1'b1;
          end
        end
        priority if (srv == FUNC_SRV || srv == NO_ID) begin
          nxt.last_server = srv;
        end else if (srv != cur_i.last_server) begin
          res.send_tester = 1'b1;
          nxt.s3_count    = cfg_i.s3_ticks;
          nxt.last_server = srv;
        end else if (s3_dec == 16'd0) begin
          res.send_tester = 1'b1;
          nxt.s3_count    = cfg_i.s3_ticks;
        end else begin
          nxt.s3_count = s3_dec;
        end
        if (res.send_tester) begin
          res.send_channel = srv;
          res.send_service = TP_SID;
          res.send_params  = TP_PARAMS;
          res.send_length  = TP_LEN;
        end
      end
      CMD_REQUEST: begin
        if (cur_i.session != ST_IDLE) begin
          res.status = RC_BUSY;
        end else begin
          nxt.addr_functional = item_i.functional;
          nxt.pending_service = item_i.service_id;
          if (req_ch >= NUM_CH) begin
            res.status = RC_NOT_OK;
          end else if (req_len != 3'd0) begin
            nxt.session         = ST_REQUEST;
            nxt.pending_channel = req_ch;
            res.send_request    = 1'b1;
            res.send_channel    = req_ch;
            res.send_service    = item_i.service_id;
            res.send_params     = item_i.request_params;
            res.send_length     = req_len;
          end
        end
      end
      CMD_TX_DONE: begin
        if (cur_i.session == ST_REQUEST) begin
          nxt.session    = ST_CONFIRM;
          nxt.p2_running = 1'b1;
          nxt.p2_count   = cfg_i.p2_ticks;
        end
      end
      CMD_FIRST: begin
        if (!cur_i.addr_functional && item_i.result_ok &&
            item_i.channel == cur_i.pending_channel &&
            (cur_i.session == ST_CONFIRM || cur_i.session == ST_PENDING)) begin
          nxt.session    = ST_FIRST;
          nxt.p2_running = 1'b0;
        end
      end
      CMD_RESPONSE: begin
        if (!item_i.result_ok) begin
          if (!cur_i.addr_functional) begin
            nxt.session = ST_IDLE;
          end
        end else if (cur_i.addr_functional) begin
          accept_rsp = 1'b1;
        end else if (item_i.channel == cur_i.pending_channel &&
                     (cur_i.session == ST_CONFIRM || cur_i.session == ST_FIRST ||
                      cur_i.session == ST_PENDING)) begin
          accept_rsp = 1'b1;
          // physical addressing: outcome of the checks sets the timer
          if (rc == RC_OK) begin
            nxt.session    = ST_IDLE;
            nxt.p2_running = 1'b0;
          end else if (rc == RC_PENDING) begin
            nxt.session    = ST_PENDING;
            nxt.p2_running = 1'b1;
            nxt.p2_count   = cfg_i.p2_star_ticks;
          end else begin
            nxt.session    = ST_INDICATION;
            nxt.p2_running = 1'b1;
            nxt.p2_count   = cfg_i.p2_ticks;
          end
        end
        if (accept_rsp) begin
          res.status = rc;
          if (rc == RC_OK) begin
            if (item_i.resp_first == NEG_SID) begin
              res.negative_flag = 1'b1;
              res.negative_code = item_i.resp_third;
            end else begin
              res.positive_flag = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.session_state = nxt.session;
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule
`default_nettype wire

// ===== rtl/uds_client_session_fsm.sv =====
// top level: diagnostic session client with p2/p2 star and s3 timing
//
//  port group   direction  payload     flow control
//  in_*         input      sess_in_t   in_valid_i / in_stall_o
//  out_*        output     sess_out_t  out_valid_o / out_stall_i
//  apb          input      p2/s3 regs  psel, penable, pready
//
//  one transaction per cycle while the output is not stalled; a result passes
//  through the input register, step logic and result register
//  session state advances when the input register moves into the result register
//  reset clears session state and loads the timing registers with their defaults
//  a held result stalls the input register, which then stalls the input side
`default_nettype none
module uds_client_session_fsm
  import uds_sess_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS   = 6,
  parameter int unsigned FUNC_SERVER_ID = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sess_in_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sess_out_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  sess_cfg_t   cfg;
  sess_in_t    in_q;
  logic        in_valid_q;
  logic        in_valid_d;
  sess_state_t state_q;
  sess_state_t state_d;
  sess_out_t   res_d;
  sess_out_t   out_q;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        fire;
  logic        in_accept;

  uds_sess_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uds_sess_step #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .FUNC_SERVER_ID (FUNC_SERVER_ID)
  ) u_step (
    .item_i (in_q),
    .cur_i  (state_q),
    .cfg_i  (cfg),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  assign fire        = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~fire;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign in_valid_d  = in_accept | (in_valid_q & ~fire);
  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/uds_sess_checker.sv =====
// port-level checks for the session client, bound to the top level
`default_nettype none
module uds_sess_checker
  import uds_sess_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire sess_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.send_request && out_data_o.send_tester))
    else $error("request and tester present in one transaction");

  a_one_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.negative_flag && out_data_o.positive_flag))
    else $error("negative and positive dispatch together");

  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.timeout_flag |-> out_data_o.session_state == ST_IDLE)
    else $error("timeout without return to idle");

endmodule

bind uds_client_session_fsm uds_sess_checker u_chk (.*);
`default_nettype wire
